// File: rtl/mlqs_pkg.sv
// Package for the multi-line queue and stack manager.
// Holds the sizes, command and status codes and the controller state type.
// No dependencies.
package mlqs_pkg;

  // Sizes
  localparam int unsigned MaxLines  = 8;
  localparam int unsigned PoolNodes = 256;
  localparam int unsigned NodeW     = $clog2(PoolNodes);
  localparam int unsigned LineW     = $clog2(MaxLines);
  localparam int unsigned CountW    = $clog2(PoolNodes + 1);
  localparam int unsigned ValueW    = 32;
  localparam int unsigned OpW       = 3;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CfgW      = 4;

  // Command codes
  typedef enum logic [OpW-1:0] {
    OP_NEW = 3'd0,
    OP_MOV = 3'd1,
    OP_DEF = 3'd2,
    OP_FIX = 3'd3,
    OP_TSH = 3'd4,
    OP_RDY = 3'd5
  } opcode_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 3'd0,
    ST_READY = 3'd1,
    ST_BAD   = 3'd2,
    ST_EMPTY = 3'd3,
    ST_FULL  = 3'd4,
    ST_LINE  = 3'd5
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

// File: rtl/multi_line_queue_and_stack_manager.sv
// Multi-line queue and stack manager: per-line FIFO queues and LIFO stacks
// kept as linked lists in a shared node pool (link and value memories).
// Depends on mlqs_pkg.
// Timing: the accepting edge issues the node memory read into registers; the
// execute state then does the read-modify-write and registers the result. A
// new item is accepted only once the previous one has left execute (the
// synchronous read comes before the relink write); a stalled result holds the
// next item in execute. Reset: all lists empty, free list chained in node order
// (per-node valid bits stand in for the chain, so no clearing pass).
module multi_line_queue_and_stack_manager (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // config
  input  logic                                    cfg_we_i,
  input  logic [mlqs_pkg::CfgW-1:0]               cfg_wdata_i,
  // input channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [mlqs_pkg::OpW-1:0]                opcode_i,
  input  logic [mlqs_pkg::LineW-1:0]              line_i,
  input  logic signed [mlqs_pkg::ValueW-1:0]      item_value_i,
  // output channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [mlqs_pkg::ValueW-1:0]      result_value_o,
  output logic [mlqs_pkg::StatusW-1:0]            status_o
);

  localparam int unsigned NodeW  = mlqs_pkg::NodeW;
  localparam int unsigned LineW  = mlqs_pkg::LineW;
  localparam int unsigned CountW = mlqs_pkg::CountW;
  localparam int unsigned ValueW = mlqs_pkg::ValueW;
  localparam int unsigned Lines  = mlqs_pkg::MaxLines;
  localparam int unsigned Nodes  = mlqs_pkg::PoolNodes;

  // Node memories
  logic [NodeW-1:0]  link_mem [Nodes];
  logic [ValueW-1:0] value_mem [Nodes];
  logic [Nodes-1:0]  link_vld_q;

  // Per-line list heads
  logic [NodeW-1:0] qfront_q [Lines];
  logic [NodeW-1:0] qfront_d [Lines];
  logic [NodeW-1:0] qback_q  [Lines];
  logic [NodeW-1:0] qback_d  [Lines];
  logic [Lines-1:0] qempty_q, qempty_d;
  logic [NodeW-1:0] stop_q   [Lines];
  logic [NodeW-1:0] stop_d   [Lines];
  logic [Lines-1:0] sempty_q, sempty_d;

  logic [NodeW-1:0]  free_head_q, free_head_d;
  logic [CountW-1:0] free_count_q, free_count_d;
  logic [mlqs_pkg::CfgW-1:0] lines_q;

  mlqs_pkg::state_e state_q, state_d;

  // Latched command and read results
  mlqs_pkg::opcode_e op_q;
  logic [LineW-1:0]  line_q;
  logic [ValueW-1:0] val_q;
  logic [NodeW-1:0]  n_q;
  logic [NodeW-1:0]  rd_link_q;
  logic [ValueW-1:0] rd_value_q;
  logic              rd_vld_q;
  logic [NodeW-1:0]  link_rd;

  // Output register
  logic              out_valid_q;
  logic [ValueW-1:0] res_q, res_d;
  mlqs_pkg::status_e st_q, st_d;

  logic             in_fire, exec_fire;
  logic [NodeW-1:0] rd_addr;
  logic [LineW-1:0] src, dst;
  logic             line_ok;
  logic             do_alloc, do_take, do_pop, do_append, do_push, do_free;
  logic             link_we, val_we;
  logic [NodeW-1:0] link_waddr, link_wdata;

  assign in_stall_o     = (state_q != mlqs_pkg::S_IDLE);
  assign in_fire        = in_valid_i && !in_stall_o;
  assign exec_fire      = (state_q == mlqs_pkg::S_EXEC) && (!out_valid_q || !out_stall_i);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign status_o       = st_q;

  // Read address: node at the head of the source list
  always_comb begin
    case (mlqs_pkg::opcode_e'(opcode_i))
      mlqs_pkg::OP_NEW: rd_addr = free_head_q;
      mlqs_pkg::OP_MOV: rd_addr = qfront_q[0];
      mlqs_pkg::OP_FIX,
      mlqs_pkg::OP_TSH: rd_addr = stop_q[line_i];
      default:          rd_addr = qfront_q[line_i];
    endcase
  end

  // Never-written links read as the reset free chain
  assign link_rd = rd_vld_q ? rd_link_q : NodeW'(n_q + 1'b1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mlqs_pkg::S_IDLE: if (in_fire) state_d = mlqs_pkg::S_EXEC;
      mlqs_pkg::S_EXEC: if (exec_fire) state_d = mlqs_pkg::S_IDLE;
      default:          state_d = mlqs_pkg::S_IDLE;
    endcase
  end

  // Command decode: checks in order line, emptiness; NEW checks only the pool
  assign line_ok = (32'(line_q) < 32'(lines_q)) && (32'(line_q) < Lines);
  assign src     = (op_q == mlqs_pkg::OP_MOV) ? '0 : line_q;
  assign dst     = (op_q == mlqs_pkg::OP_NEW) ? '0 : line_q;

  always_comb begin
    do_alloc  = 1'b0;
    do_take   = 1'b0;
    do_pop    = 1'b0;
    do_append = 1'b0;
    do_push   = 1'b0;
    do_free   = 1'b0;
    st_d      = mlqs_pkg::ST_DONE;
    res_d     = '0;
    case (op_q)
      mlqs_pkg::OP_NEW: begin
        if (free_count_q == '0) begin
          st_d = mlqs_pkg::ST_FULL;
        end else begin
          do_alloc  = 1'b1;
          do_append = 1'b1;
          res_d     = val_q;
        end
      end
      mlqs_pkg::OP_MOV, mlqs_pkg::OP_DEF, mlqs_pkg::OP_RDY: begin
        if (!line_ok) begin
          st_d = mlqs_pkg::ST_LINE;
        end else if (qempty_q[src]) begin
          st_d = mlqs_pkg::ST_EMPTY;
        end else begin
          do_take   = 1'b1;
          do_append = (op_q == mlqs_pkg::OP_MOV);
          do_push   = (op_q == mlqs_pkg::OP_DEF);
          do_free   = (op_q == mlqs_pkg::OP_RDY);
          res_d     = rd_value_q;
          if (op_q == mlqs_pkg::OP_RDY) st_d = mlqs_pkg::ST_READY;
        end
      end
      mlqs_pkg::OP_FIX, mlqs_pkg::OP_TSH: begin
        if (!line_ok) begin
          st_d = mlqs_pkg::ST_LINE;
        end else if (sempty_q[line_q]) begin
          st_d = mlqs_pkg::ST_EMPTY;
        end else begin
          do_pop    = 1'b1;
          do_append = (op_q == mlqs_pkg::OP_FIX);
          do_free   = (op_q == mlqs_pkg::OP_TSH);
          res_d     = rd_value_q;
          if (op_q == mlqs_pkg::OP_TSH) st_d = mlqs_pkg::ST_BAD;
        end
      end
      default: ;  // unused opcodes: no operation
    endcase
  end

  // List update: unlink first, then relink; at most one link write
  always_comb begin
    qfront_d     = qfront_q;
    qback_d      = qback_q;
    qempty_d     = qempty_q;
    stop_d       = stop_q;
    sempty_d     = sempty_q;
    free_head_d  = free_head_q;
    free_count_d = free_count_q;
    link_we      = 1'b0;
    link_waddr   = n_q;
    link_wdata   = n_q;
    val_we       = 1'b0;
    if (exec_fire) begin
      if (do_alloc) begin
        free_head_d  = link_rd;
        free_count_d = free_count_q - 1'b1;
        val_we       = 1'b1;
      end
      if (do_take) begin
        if (n_q == qback_q[src]) qempty_d[src] = 1'b1;
        else                     qfront_d[src] = link_rd;
      end
      if (do_pop) begin
        if (link_rd == n_q) sempty_d[line_q] = 1'b1;
        else                stop_d[line_q]   = link_rd;
      end
      if (do_append) begin
        if (qempty_d[dst]) begin
          qfront_d[dst] = n_q;
          qempty_d[dst] = 1'b0;
        end else begin
          link_we    = 1'b1;
          link_waddr = qback_d[dst];
          link_wdata = n_q;
        end
        qback_d[dst] = n_q;
      end
      if (do_push) begin
        link_we          = 1'b1;
        link_wdata       = sempty_q[line_q] ? n_q : stop_q[line_q];
        stop_d[line_q]   = n_q;
        sempty_d[line_q] = 1'b0;
      end
      if (do_free) begin
        link_we      = 1'b1;
        link_wdata   = free_head_q;
        free_head_d  = n_q;
        free_count_d = free_count_q + 1'b1;
      end
    end
  end

  // Node memories: read on accept, write back in the execute cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_link_q  <= link_mem[rd_addr];
      rd_value_q <= value_mem[rd_addr];
    end
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (val_we)  value_mem[n_q] <= val_q;
  end

  // Command latch (payload)
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= mlqs_pkg::opcode_e'(opcode_i);
      line_q <= line_i;
      val_q  <= item_value_i;
      n_q    <= rd_addr;
    end
    if (exec_fire) begin
      res_q <= res_d;
      st_q  <= st_d;
    end
  end

  // Control and list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mlqs_pkg::S_IDLE;
      out_valid_q  <= 1'b0;
      link_vld_q   <= '0;
      rd_vld_q     <= 1'b0;
      free_head_q  <= '0;
      free_count_q <= CountW'(Nodes);
      qempty_q     <= '1;
      sempty_q     <= '1;
      lines_q      <= mlqs_pkg::CfgW'(Lines);
      for (int i = 0; i < Lines; i++) begin
        qfront_q[i] <= '0;
        qback_q[i]  <= '0;
        stop_q[i]   <= '0;
      end
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      free_count_q <= free_count_d;
      qfront_q     <= qfront_d;
      qback_q      <= qback_d;
      qempty_q     <= qempty_d;
      stop_q       <= stop_d;
      sempty_q     <= sempty_d;
      if (cfg_we_i) lines_q <= cfg_wdata_i;
      if (in_fire) rd_vld_q <= link_vld_q[rd_addr];
      if (link_we) link_vld_q[link_waddr] <= 1'b1;
      if (exec_fire)               out_valid_q <= 1'b1;
      else if (!out_stall_i)       out_valid_q <= 1'b0;
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= CountW'(Nodes))
    else $error("free count above pool size");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == mlqs_pkg::S_EXEC))
    else $error("accepted item not executed next");

  a_full_only_empty_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && st_d == mlqs_pkg::ST_FULL) |-> (free_count_q == '0))
    else $error("pool full reported with free nodes");

  a_exec_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> (out_valid_q && st_q == $past(st_d)))
    else $error("result not registered");

endmodule
